// ===== rtl/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dpw_pkg: shared types and constants for the dotted date parser
// Character codes, saturation limits, the record that travels from the
// parser to the date evaluator, and the small month tables.
// ----------------------------------------------------------------------------
package dpw_pkg;

  localparam int DAY_W   = 8;
  localparam int MONTH_W = 8;
  localparam int YEAR_W  = 27;
  localparam int WDAY_W  = 3;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [DAY_W-1:0]   DAY_MAX   = 8'd255;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 8'd255;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 27'd99999999;

  // floor(a / 25) = (a * RECIP25) >> RECIP_SHIFT, exact for a < 2^30
  localparam int              QUOT_W      = 25;
  localparam int              RECIP_W     = 26;
  localparam int              PROD_W      = QUOT_W + RECIP_W;
  localparam int              RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP25  = 26'd42949673;
  localparam int              Q_W         = PROD_W - RECIP_SHIFT;

  // weekday sum, padded to whole octal digits for the mod-7 fold
  localparam int SUM_W    = 30;
  localparam int SUM_DIGS = SUM_W / 3;
  localparam int DSUM_W   = 7;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 8'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 8'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 8'd12;
  localparam logic [YEAR_W-1:0]  YEAR_SHIFT = 27'd400;
  localparam logic [4:0]         FEB_LEAP_DAYS = 5'd29;
  localparam logic [3:0]         MOD7 = 4'd7;
  localparam logic [WDAY_W-1:0]  WDAY_SUNDAY = 3'd7;
  localparam logic [WDAY_W-1:0]  WDAY_NONE   = 3'd0;

  typedef enum logic [1:0] {
    FIELD_DAY   = 2'd0,
    FIELD_MONTH = 2'd1,
    FIELD_YEAR  = 2'd2,
    FIELD_EXTRA = 2'd3
  } field_t;

  typedef struct packed {
    logic                seen;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
  } dpw_rec_t;

  function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] r;
    case (m)
      8'd1:    r = 3'd0;
      8'd2:    r = 3'd3;
      8'd3:    r = 3'd2;
      8'd4:    r = 3'd5;
      8'd5:    r = 3'd0;
      8'd6:    r = 3'd3;
      8'd7:    r = 3'd5;
      8'd8:    r = 3'd1;
      8'd9:    r = 3'd4;
      8'd10:   r = 3'd6;
      8'd11:   r = 3'd2;
      8'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m);
    logic [4:0] r;
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: r = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                     r = 5'd30;
      8'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/dpw_front.sv =====
// ----------------------------------------------------------------------------
// dpw_front: character parser
// Takes one character per transaction, builds the three field numbers with
// saturation, and hands a finished record to the queue on the NUL.
// ----------------------------------------------------------------------------
module dpw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              ch_valid,
  input  logic [7:0]        ch,
  output logic              ch_ready,
  output logic              push_valid,
  output dpw_pkg::dpw_rec_t push_rec,
  input  logic              push_ready
);

  dpw_pkg::field_t field_index, field_index_next;
  logic [dpw_pkg::DAY_W-1:0]   day_acc, day_acc_next;
  logic [dpw_pkg::MONTH_W-1:0] month_acc, month_acc_next;
  logic [dpw_pkg::YEAR_W-1:0]  year_acc, year_acc_next;
  logic digits_stopped, digits_stopped_next;
  logic any_char_seen, any_char_seen_next;

  logic       take;
  logic       is_digit;
  logic [3:0] digit;
  logic [11:0] day_x10, month_x10;
  logic [30:0] year_x10;

  assign ch_ready = push_ready;
  assign take     = ch_valid && ch_ready;
  assign is_digit = (ch >= dpw_pkg::CH_ZERO) && (ch <= dpw_pkg::CH_NINE);
  assign digit    = ch[3:0];

  // acc * 10 + digit as shift-add
  assign day_x10   = {1'b0, day_acc, 3'b0} + {3'b0, day_acc, 1'b0} + 12'(digit);
  assign month_x10 = {1'b0, month_acc, 3'b0} + {3'b0, month_acc, 1'b0} + 12'(digit);
  assign year_x10  = {1'b0, year_acc, 3'b0} + {3'b0, year_acc, 1'b0} + 31'(digit);

  assign push_valid    = take && (ch == dpw_pkg::CH_NUL);
  assign push_rec.seen  = any_char_seen;
  assign push_rec.day   = day_acc;
  assign push_rec.month = month_acc;
  assign push_rec.year  = year_acc;

  always_comb begin
    field_index_next    = field_index;
    day_acc_next        = day_acc;
    month_acc_next      = month_acc;
    year_acc_next       = year_acc;
    digits_stopped_next = digits_stopped;
    any_char_seen_next  = any_char_seen;
    if (take) begin
      if (ch == dpw_pkg::CH_NUL) begin
        field_index_next    = dpw_pkg::FIELD_DAY;
        day_acc_next        = '0;
        month_acc_next      = '0;
        year_acc_next       = '0;
        digits_stopped_next = 1'b0;
        any_char_seen_next  = 1'b0;
      end else if (ch == dpw_pkg::CH_DOT) begin
        any_char_seen_next  = 1'b1;
        digits_stopped_next = 1'b0;
        case (field_index)
          dpw_pkg::FIELD_DAY:   field_index_next = dpw_pkg::FIELD_MONTH;
          dpw_pkg::FIELD_MONTH: field_index_next = dpw_pkg::FIELD_YEAR;
          default:              field_index_next = dpw_pkg::FIELD_EXTRA;
        endcase
      end else if (is_digit) begin
        any_char_seen_next = 1'b1;
        if (!digits_stopped) begin
          case (field_index)
            dpw_pkg::FIELD_DAY:
              day_acc_next = (day_x10 > 12'(dpw_pkg::DAY_MAX)) ?
                             dpw_pkg::DAY_MAX : day_x10[7:0];
            dpw_pkg::FIELD_MONTH:
              month_acc_next = (month_x10 > 12'(dpw_pkg::MONTH_MAX)) ?
                               dpw_pkg::MONTH_MAX : month_x10[7:0];
            dpw_pkg::FIELD_YEAR:
              year_acc_next = (year_x10 > 31'(dpw_pkg::YEAR_MAX)) ?
                              dpw_pkg::YEAR_MAX : year_x10[26:0];
            default: ;
          endcase
        end
      end else begin
        any_char_seen_next  = 1'b1;
        digits_stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index    <= dpw_pkg::FIELD_DAY;
      day_acc        <= '0;
      month_acc      <= '0;
      year_acc       <= '0;
      digits_stopped <= 1'b0;
      any_char_seen  <= 1'b0;
    end else begin
      field_index    <= field_index_next;
      day_acc        <= day_acc_next;
      month_acc      <= month_acc_next;
      year_acc       <= year_acc_next;
      digits_stopped <= digits_stopped_next;
      any_char_seen  <= any_char_seen_next;
    end
  end

endmodule

// ===== rtl/dpw_queue.sv =====
// ----------------------------------------------------------------------------
// dpw_queue: record queue between parser and evaluator
// Small register FIFO; lets the parser keep taking characters while the
// evaluator is stalled.
// ----------------------------------------------------------------------------
module dpw_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  dpw_pkg::dpw_rec_t push_rec,
  output logic              push_ready,
  output logic              pop_valid,
  output dpw_pkg::dpw_rec_t pop_rec,
  input  logic              pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dpw_pkg::dpw_rec_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic push, pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_rec    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/dpw_back.sv =====
// ----------------------------------------------------------------------------
// dpw_back: date evaluator pipeline
// Four stages: reciprocal divides by 25, leap test and weekday sum,
// octal digit fold, final mod 7 into the output register.
// ----------------------------------------------------------------------------
module dpw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rec_valid,
  input  dpw_pkg::dpw_rec_t           rec,
  output logic                        rec_ready,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        valid_res,
  output logic [dpw_pkg::DAY_W-1:0]   day,
  output logic [dpw_pkg::MONTH_W-1:0] month,
  output logic [dpw_pkg::YEAR_W-1:0]  year,
  output logic [dpw_pkg::WDAY_W-1:0]  weekday
);

  logic en1, en2, en3, en4;

  // stage 1
  logic                         v1, seen1, mok1;
  logic [dpw_pkg::DAY_W-1:0]    d1;
  logic [dpw_pkg::MONTH_W-1:0]  m1;
  logic [dpw_pkg::YEAR_W-1:0]   y1, yy1;
  logic [dpw_pkg::Q_W-1:0]      q100_1, qb1;
  logic [dpw_pkg::YEAR_W-1:0]   yy;
  logic [dpw_pkg::PROD_W-1:0]   prod_a, prod_b;
  logic                         mok;

  // stage 2
  logic                         v2, mok2, ok2;
  logic [dpw_pkg::DAY_W-1:0]    d2;
  logic [dpw_pkg::MONTH_W-1:0]  m2;
  logic [dpw_pkg::YEAR_W-1:0]   y2;
  logic [dpw_pkg::SUM_W-1:0]    sum2, sum_c;
  logic [dpw_pkg::QUOT_W-1:0]   mul25, r25;
  logic                         leap;
  logic [4:0]                   dim;
  logic                         date_ok;

  // stage 3
  logic                         v3, mok3, ok3;
  logic [dpw_pkg::DAY_W-1:0]    d3;
  logic [dpw_pkg::MONTH_W-1:0]  m3;
  logic [dpw_pkg::YEAR_W-1:0]   y3;
  logic [dpw_pkg::DSUM_W-1:0]   dsum3, dsum_c;

  // stage 4
  logic [3:0]                   s_a, s_b;
  logic [dpw_pkg::WDAY_W-1:0]   w_c;

  assign en4       = !res_valid || res_ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign rec_ready = en1;

  // ---- stage 1: shifted year and two divides by 25 ----
  assign mok    = (rec.month != '0) && (rec.month <= dpw_pkg::MONTH_DEC);
  assign yy     = rec.year + dpw_pkg::YEAR_SHIFT -
                  dpw_pkg::YEAR_W'(rec.month < dpw_pkg::MONTH_MAR);
  assign prod_a = yy[26:2] * dpw_pkg::RECIP25;
  assign prod_b = rec.year[26:2] * dpw_pkg::RECIP25;

  always_ff @(posedge clk) begin
    if (en1) begin
      seen1  <= rec.seen;
      mok1   <= mok;
      d1     <= rec.day;
      m1     <= rec.month;
      y1     <= rec.year;
      yy1    <= yy;
      q100_1 <= prod_a[dpw_pkg::PROD_W-1:dpw_pkg::RECIP_SHIFT];
      qb1    <= prod_b[dpw_pkg::PROD_W-1:dpw_pkg::RECIP_SHIFT];
    end
  end

  // ---- stage 2: leap test, date check, weekday sum ----
  assign mul25 = {qb1[20:0], 4'b0} + {1'b0, qb1[20:0], 3'b0} + dpw_pkg::QUOT_W'(qb1);
  assign r25   = y1[26:2] - mul25;
  // y divisible by 4; by 100 when y/4 is a multiple of 25; by 400 also needs
  // the quotient y/100 even twice over
  assign leap  = (y1[1:0] == 2'b00) && ((r25 != '0) || (qb1[1:0] == 2'b00));

  always_comb begin
    dim = dpw_pkg::month_days(m1);
    if ((m1 == dpw_pkg::MONTH_FEB) && leap) begin
      dim = dpw_pkg::FEB_LEAP_DAYS;
    end
  end

  assign date_ok = mok1 && (d1 != '0) && (d1 <= dpw_pkg::DAY_W'(dim));

  // yy + yy/4 - yy/100 + yy/400 + offset + day
  assign sum_c = dpw_pkg::SUM_W'(yy1) + dpw_pkg::SUM_W'(yy1[26:2]) +
                 dpw_pkg::SUM_W'(q100_1[dpw_pkg::Q_W-1:2]) +
                 dpw_pkg::SUM_W'(dpw_pkg::month_offset(m1)) +
                 dpw_pkg::SUM_W'(d1) - dpw_pkg::SUM_W'(q100_1);

  always_ff @(posedge clk) begin
    if (en2) begin
      mok2 <= mok1;
      ok2  <= seen1 && date_ok;
      d2   <= d1;
      m2   <= m1;
      y2   <= y1;
      sum2 <= sum_c;
    end
  end

  // ---- stage 3: octal digit sum (8 == 1 mod 7) ----
  always_comb begin
    dsum_c = '0;
    for (int i = 0; i < dpw_pkg::SUM_DIGS; i++) begin
      dsum_c = dsum_c + dpw_pkg::DSUM_W'(sum2[3*i +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      mok3  <= mok2;
      ok3   <= ok2;
      d3    <= d2;
      m3    <= m2;
      y3    <= y2;
      dsum3 <= dsum_c;
    end
  end

  // ---- stage 4: fold to 0..8, final subtract ----
  assign s_a = 4'(dsum3[2:0]) + 4'(dsum3[5:3]) + 4'(dsum3[6]);
  assign s_b = 4'(s_a[2:0]) + 4'(s_a[3]);
  assign w_c = (s_b >= dpw_pkg::MOD7) ? 3'(s_b - dpw_pkg::MOD7) : s_b[2:0];

  always_ff @(posedge clk) begin
    if (en4) begin
      valid_res <= ok3;
      day       <= d3;
      month     <= m3;
      year      <= y3;
      if (!mok3) begin
        weekday <= dpw_pkg::WDAY_NONE;
      end else if (w_c == '0) begin
        weekday <= dpw_pkg::WDAY_SUNDAY;
      end else begin
        weekday <= w_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= rec_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        res_valid <= v3;
      end
    end
  end

endmodule

// ===== rtl/dotted_date_parser_weekday_core.sv =====
// ----------------------------------------------------------------------------
// dotted_date_parser_weekday_core: dotted date parser with weekday
// Parses "day.month.year" text one character per transaction, ending with
// NUL, and returns the numbers, a Gregorian validity flag and the weekday.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | ch_valid / ch_ready  | ch
//  result  | res_valid/ res_ready | valid_res, day, month, year, weekday
//
//  One character is taken every cycle; ch_ready drops only when the record
//  queue is full, i.e. after the result side has stalled long enough.
//  After its NUL transaction a record is registered in the queue and then
//  passes the evaluator's stages (divide-by-25 multiply, leap/sum, digit fold,
//  mod 7 into the output register). Evaluator stages advance independently,
//  so bubbles collapse; with res_ready high a result can leave every cycle.
//  Synchronous reset clears the parser fields, the queue and all stage
//  valid bits; no result is pending after reset.
//
module dotted_date_parser_weekday_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ch_valid,
  output logic                        ch_ready,
  input  logic [7:0]                  ch,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        valid_res,
  output logic [dpw_pkg::DAY_W-1:0]   day,
  output logic [dpw_pkg::MONTH_W-1:0] month,
  output logic [dpw_pkg::YEAR_W-1:0]  year,
  output logic [dpw_pkg::WDAY_W-1:0]  weekday
);

  // parser -> queue
  logic              push_valid, push_ready;
  dpw_pkg::dpw_rec_t push_rec;
  // queue -> evaluator
  logic              pop_valid, pop_ready;
  dpw_pkg::dpw_rec_t pop_rec;

  // Front: accumulates fields, emits a record per NUL
  dpw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ch_valid   (ch_valid),
    .ch         (ch),
    .ch_ready   (ch_ready),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready)
  );

  // Decoupling queue so parsing continues while results back up
  dpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_rec    (pop_rec),
    .pop_ready  (pop_ready)
  );

  // Back: validity and weekday evaluation
  dpw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (pop_valid),
    .rec       (pop_rec),
    .rec_ready (pop_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .valid_res (valid_res),
    .day       (day),
    .month     (month),
    .year      (year),
    .weekday   (weekday)
  );

  // ---- assertions ----

  // nothing pending straight out of reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // weekday is zero exactly when the month is out of range
  a_wday_month: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((weekday == dpw_pkg::WDAY_NONE) ==
                   ((month == '0) || (month > dpw_pkg::MONTH_DEC))))
    else $error("weekday inconsistent with month");

  // a valid date has a day of 1..31 and a month of 1..12
  a_valid_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && valid_res) |->
      ((day != '0) && (day <= 8'd31) && (month != '0) &&
       (month <= dpw_pkg::MONTH_DEC)))
    else $error("valid date with out-of-range fields");

endmodule
